[src/mbrc_pkg.sv]
package mbrc_pkg;

   // Frame buffer limit; bytes past this are dropped.
   localparam int MAX_FRAME_BYTES = 256;
   localparam int LEN_W           = 9;
   localparam int MIN_FRAME_BYTES = 3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;
   localparam logic [1:0] STATUS_BAD_FUNC  = 2'd3;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       func_code;
      logic [LEN_W-1:0] frame_length;
   } result_type;

   // One entry of the reflected CRC-16 table, built at elaboration where constant.
   function automatic logic [15:0] crc_table(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'h00, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      return {8'h00, crc[15:8]} ^ crc_table(crc[7:0] ^ b);
   endfunction

endpackage

[src/mbrc_frame_acc.sv]
module mbrc_frame_acc (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  logic                 last_byte,
   output logic                 done,
   output mbrc_pkg::result_type result
);
   import mbrc_pkg::*;

   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held_one_ff, held_one_in;
   logic [7:0]       held_two_ff, held_two_in;
   logic [7:0]       func_ff, func_in;
   logic [LEN_W-1:0] count_ff, count_in;

   // values after taking the current byte, before any end-of-frame clear
   logic [15:0]      crc_nx;
   logic [7:0]       held_one_nx, held_two_nx, func_nx;
   logic [LEN_W-1:0] count_nx;
   logic             keep;
   logic [15:0]      rcvd_crc;

   assign keep = count_ff < LEN_W'(MAX_FRAME_BYTES);

   always_comb begin
      crc_nx      = crc_ff;
      func_nx     = func_ff;
      held_one_nx = held_one_ff;
      held_two_nx = held_two_ff;
      count_nx    = count_ff;
      if (keep) begin
         // the two newest bytes are held back as the trailing CRC
         if (count_ff >= LEN_W'(2)) begin
            crc_nx = crc_feed(crc_ff, held_one_ff);
         end
         if (count_ff == LEN_W'(1)) begin
            func_nx = rx_byte;
         end
         held_one_nx = held_two_ff;
         held_two_nx = rx_byte;
         count_nx    = count_ff + LEN_W'(1);
      end
   end

   assign rcvd_crc = {held_two_nx, held_one_nx};
   assign done     = accept && last_byte;

   always_comb begin
      if (count_nx < LEN_W'(MIN_FRAME_BYTES)) begin
         result.status = STATUS_TOO_SHORT;
      end else if (crc_nx != rcvd_crc) begin
         result.status = STATUS_CRC_ERR;
      end else if (func_nx == FUNC_READ_HOLDING || func_nx == FUNC_WRITE_SINGLE) begin
         result.status = STATUS_OK;
      end else begin
         result.status = STATUS_BAD_FUNC;
      end
      result.func_code    = (count_nx >= LEN_W'(2)) ? func_nx : 8'h00;
      result.frame_length = count_nx;
   end

   always_comb begin
      crc_in      = crc_ff;
      held_one_in = held_one_ff;
      held_two_in = held_two_ff;
      func_in     = func_ff;
      count_in    = count_ff;
      if (accept) begin
         if (last_byte) begin
            crc_in      = CRC_INIT;
            held_one_in = 8'h00;
            held_two_in = 8'h00;
            func_in     = 8'h00;
            count_in    = '0;
         end else begin
            crc_in      = crc_nx;
            held_one_in = held_one_nx;
            held_two_in = held_two_nx;
            func_in     = func_nx;
            count_in    = count_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         held_one_ff <= 8'h00;
         held_two_ff <= 8'h00;
         func_ff     <= 8'h00;
         count_ff    <= '0;
      end else begin
         crc_ff      <= crc_in;
         held_one_ff <= held_one_in;
         held_two_ff <= held_two_in;
         func_ff     <= func_in;
         count_ff    <= count_in;
      end
   end

endmodule

[src/modbus_rtu_response_checker_unit.sv]
// Modbus RTU response checker. Feed the received frame one byte per transaction in
// wire order, with req_last_byte set on the final byte. One byte is taken every
// clock cycle while req_stall is low; the CRC-16 update (one table lookup and XOR
// on the running value) sits between the frame state registers and the result
// register: the output register, or the skid entry while the output is held.
// Only the final byte yields a result transaction: status (too short, CRC
// mismatch, unsupported function code, checked in that order, else ok), the
// function code and the number of bytes kept (bytes past MAX_FRAME_BYTES are
// dropped). A two-entry result buffer lets input continue while a result is
// held; req_stall rises only when both entries are full.
module modbus_rtu_response_checker_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [7:0]                 rsp_func_code,
   output logic [mbrc_pkg::LEN_W-1:0] rsp_frame_length
);
   import mbrc_pkg::*;

   logic       req_accept;
   logic       rsp_fire;
   logic       new_done;
   result_type new_result;

   // output register plus skid entry
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff,  out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_fire   = out_valid_ff && !rsp_stall;

   mbrc_frame_acc u_frame_acc (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_rx_byte),
      .last_byte (req_last_byte),
      .done      (new_done),
      .result    (new_result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_fire) begin
         // output free: drain skid first; input is stalled while skid is full
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_done;
            out_data_in  = new_result;
         end
      end else if (new_done) begin
         // output held by a stall: park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = new_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_data_ff.status;
   assign rsp_func_code    = out_data_ff.func_code;
   assign rsp_frame_length = out_data_ff.frame_length;

endmodule

[src/mbrc_checker.sv]
module mbrc_props (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_last_byte,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_status,
   input logic [7:0]                 rsp_func_code,
   input logic [mbrc_pkg::LEN_W-1:0] rsp_frame_length
);
   import mbrc_pkg::*;

   // held result must not move
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_func_code) && $stable(rsp_frame_length))
      else $error("result changed while stalled");

   // a fresh result follows a final byte taken in the previous cycle
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte))
      else $error("result without a final byte");

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled with output free");

   // fields agree with the status
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_length <= LEN_W'(MAX_FRAME_BYTES))
         && (rsp_status == STATUS_TOO_SHORT || rsp_frame_length >= LEN_W'(MIN_FRAME_BYTES))
         && (rsp_frame_length >= LEN_W'(2) || rsp_func_code == 8'h00)
         && (rsp_status != STATUS_OK || rsp_func_code == FUNC_READ_HOLDING
             || rsp_func_code == FUNC_WRITE_SINGLE))
      else $error("result fields inconsistent");

endmodule

bind modbus_rtu_response_checker_unit mbrc_props u_mbrc_props (.*);
